// ===== hw/rtl/pcp_pkg.sv =====
// shared types and constants for the pedal calibration and plausibility block
`timescale 1ns / 1ps
`default_nettype none

package pcp_pkg;

  // default converter width
  localparam int SAMPLE_BITS_DEF = 12;

  // configuration data widths
  localparam int CFG_W = 12;
  localparam int PCT_W = 7;
  localparam int CFG_IDX_W = 3;

  // operation codes
  localparam logic [1:0] OP_CALIBRATE = 2'd0;
  localparam logic [1:0] OP_DEADZONE  = 2'd1;
  localparam logic [1:0] OP_MEASURE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_WIRE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_WIRE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_HOLD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FAULT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_RELEASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPAN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_DEAD      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DEAD    = 3'd7;

  // fixed percentages
  localparam logic [PCT_W-1:0] PCT_FULL     = 7'd100;
  localparam logic [PCT_W-1:0] DISAGREE_PCT = 7'd10;

  // sensor slots
  localparam int N_SENSORS = 3;
  localparam logic [1:0] SENSOR_BRAKE = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/pcp_div.sv =====
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pcp_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 12
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  done,
  output logic [NUM_W-1:0]      quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] work;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [CNT_W-1:0] count;
  logic             running;

  logic [DEN_W:0] rem_shift;
  logic [DEN_W:0] rem_sub;
  logic           fits;

  always_comb begin
    rem_shift = {rem, work[NUM_W-1]};
    rem_sub   = rem_shift - {1'b0, den_q};
    fits      = rem_shift >= {1'b0, den_q};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        work    <= num;
        den_q   <= den;
        rem     <= '0;
        count   <= CNT_W'(NUM_W);
        running <= 1'b1;
      end else if (running) begin
        rem   <= fits ? rem_sub[DEN_W-1:0] : rem_shift[DEN_W-1:0];
        work  <= {work[NUM_W-2:0], fits};
        count <= count - 1'b1;
        if (count == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quo = work;

endmodule

`default_nettype wire

// ===== hw/rtl/pedal_calibration_plausibility.sv =====
// pedal calibration and plausibility top level
// Input channel in_valid/in_ready carries op and the three raw readings
// (two throttle sensors, one brake sensor). Output channel out_valid/out_ready
// carries the three percents and the ready_res, disagree and implausible flags.
// One result per input transaction. Calibrate takes one step per sensor, deadzone
// two per sensor (span times percent, then a reciprocal multiply for the divide
// by 100), and an unused op goes straight to the finish step. Measure makes one
// pass per sensor through the shared restoring divider, one quotient bit per
// cycle over a SAMPLE_BITS + 7 bit dividend, then one flag step after the last
// sensor. A measure of a sensor whose window is not calibrated skips its divide.
// in_ready is high only while the sequencer is idle; one item is at work at
// a time. A finished result sits in the output register, and the next
// transaction is accepted while it waits; if the receiver stalls until the
// following result is done, the sequencer holds until the register frees.
// Reset clears the calibration marks, the fault latch and the configuration
// to their defaults; the block comes out of reset idle, with in_ready high.
// Configuration writes land at once and are meant for idle periods only.
`timescale 1ns / 1ps
`default_nettype none

module pedal_calibration_plausibility
  import pcp_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [1:0]             op,
  input  wire logic [SAMPLE_BITS-1:0] throttle_a_raw,
  input  wire logic [SAMPLE_BITS-1:0] throttle_b_raw,
  input  wire logic [SAMPLE_BITS-1:0] brake_raw,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [PCT_W-1:0]            throttle_a_pct,
  output logic [PCT_W-1:0]            throttle_b_pct,
  output logic [PCT_W-1:0]            brake_pct,
  output logic                        ready_res,
  output logic                        disagree,
  output logic                        implausible,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  localparam int SB    = SAMPLE_BITS;
  localparam int LOW_W = SB + 3;
  localparam int NUM_W = SB + 7;
  localparam int CMP_W = (SB > CFG_W) ? SB : CFG_W;

  // divide by 100 as a multiply by ceil(2^REC_SH / 100), exact below 2^NUM_W
  localparam int REC_SH = NUM_W + 7;
  localparam int REC_W  = NUM_W + 1;
  localparam int MUL_W  = 2 * NUM_W + 1;
  localparam logic [REC_W-1:0] REC_M = REC_W'(((64'd1 << REC_SH) + 64'd99) / 64'd100);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALIB,
    S_DZ_START,
    S_DZ_WAIT,
    S_MS_START,
    S_MS_WAIT,
    S_FLAGS,
    S_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [CFG_W-1:0] open_wire_limit;
  logic [CFG_W-1:0] short_wire_limit;
  logic [PCT_W-1:0] brake_hold_pct;
  logic [PCT_W-1:0] throttle_fault_pct;
  logic [PCT_W-1:0] throttle_release_pct;
  logic [CFG_W-1:0] min_span;
  logic [PCT_W-1:0] throttle_dead_pct;
  logic [PCT_W-1:0] brake_dead_pct;

  // calibration state per sensor
  logic [LOW_W-1:0] low_mark  [N_SENSORS];
  logic [SB-1:0]    high_mark [N_SENSORS];
  logic [SB-1:0]    span      [N_SENSORS];
  logic             fault_latch;

  // working registers for the current transaction
  logic [SB-1:0]    raw_q [N_SENSORS];
  logic [PCT_W-1:0] pct_q [N_SENSORS];
  logic             dis_q;
  logic             imp_q;
  logic [1:0]       sensor;

  // shared divider
  logic             div_start;
  logic [NUM_W-1:0] div_num;
  logic [SB-1:0]    div_den;
  logic             div_done;
  logic [NUM_W-1:0] div_quo;

  // current sensor view
  logic [SB-1:0]    raw_sel;
  logic [LOW_W-1:0] raw_ext;
  logic [LOW_W-1:0] lo;
  logic [SB-1:0]    hi;
  logic [SB-1:0]    sp;

  // calibrate next values
  logic [LOW_W-1:0] lo_cal;
  logic [SB-1:0]    hi_cal;
  logic [SB-1:0]    sp_cal;

  // measure
  logic [LOW_W-1:0] clamped;
  logic [SB-1:0]    above_low;
  logic             meas_skip;
  logic [PCT_W-1:0] pct_sat;

  // deadzone
  logic [PCT_W-1:0] dead_pct;
  logic [NUM_W-1:0] dz_prod;
  logic [MUL_W-1:0] dz_mul;
  logic [NUM_W-1:0] dz_val;
  logic [LOW_W-1:0] lo_dz;
  logic             dz_fits;

  // flags
  logic [PCT_W-1:0] pct_diff;
  logic             wire_fault;
  logic             dis_next;
  logic             imp_next;
  logic             ready_next;
  logic             last_sensor;

  always_comb begin
    raw_sel = raw_q[sensor];
    raw_ext = LOW_W'(raw_sel);
    lo      = low_mark[sensor];
    hi      = high_mark[sensor];
    sp      = span[sensor];
    last_sensor = (sensor == SENSOR_BRAKE);

    // calibrate: widen the window on one side
    hi_cal = hi;
    lo_cal = lo;
    if (raw_sel > hi) begin
      hi_cal = raw_sel;
    end else if (raw_ext < lo) begin
      lo_cal = raw_ext;
    end
    sp_cal = sp;
    if (LOW_W'(hi_cal) > lo_cal) begin
      sp_cal = SB'(LOW_W'(hi_cal) - lo_cal);
    end

    // measure: clamp into the window
    if (raw_sel > hi) begin
      clamped = LOW_W'(hi);
    end else if (raw_ext < lo) begin
      clamped = lo;
    end else begin
      clamped = raw_ext;
    end
    // window with low above high reads as zero
    meas_skip = (clamped < lo) || (sp == '0);
    above_low = SB'(clamped - lo);
    pct_sat   = (div_quo > NUM_W'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];

    // deadzone
    dead_pct = (sensor == SENSOR_BRAKE) ? brake_dead_pct : throttle_dead_pct;
    dz_mul   = MUL_W'(dz_prod) * MUL_W'(REC_M);
    dz_val   = NUM_W'(dz_mul[MUL_W-1:REC_SH]);
    dz_fits  = dz_val < NUM_W'(sp);
    lo_dz    = LOW_W'(NUM_W'(lo) + dz_val);

    // divider operands
    div_num   = NUM_W'(above_low) * NUM_W'(PCT_FULL);
    div_den   = sp;
    div_start = (state == S_MS_START) && !meas_skip;

    // flags
    pct_diff = (pct_q[0] > pct_q[1]) ? (pct_q[0] - pct_q[1]) : (pct_q[1] - pct_q[0]);
    wire_fault = (CMP_W'(raw_q[0]) < CMP_W'(open_wire_limit))
              || (CMP_W'(raw_q[0]) > CMP_W'(short_wire_limit))
              || (CMP_W'(raw_q[1]) < CMP_W'(open_wire_limit))
              || (CMP_W'(raw_q[1]) > CMP_W'(short_wire_limit));
    dis_next = (pct_diff > DISAGREE_PCT) || wire_fault;
    if (fault_latch) begin
      imp_next = !(pct_q[0] <= throttle_release_pct);
    end else begin
      imp_next = (pct_q[2] >= brake_hold_pct) && (pct_q[0] > throttle_fault_pct);
    end

    ready_next = (CMP_W'(span[0]) > CMP_W'(min_span))
              && (CMP_W'(span[1]) > CMP_W'(min_span))
              && (CMP_W'(span[2]) > CMP_W'(min_span));
  end

  assign in_ready = (state == S_IDLE);

  pcp_div #(
    .NUM_W(NUM_W),
    .DEN_W(SB)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      out_valid            <= 1'b0;
      fault_latch          <= 1'b0;
      open_wire_limit      <= 12'd0;
      short_wire_limit     <= 12'd4095;
      brake_hold_pct       <= 7'd10;
      throttle_fault_pct   <= 7'd25;
      throttle_release_pct <= 7'd5;
      min_span             <= 12'd0;
      throttle_dead_pct    <= 7'd5;
      brake_dead_pct       <= 7'd10;
      for (int i = 0; i < N_SENSORS; i++) begin
        low_mark[i]  <= '1;
        high_mark[i] <= '0;
        span[i]      <= SB'(1);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_OPEN_WIRE:   open_wire_limit      <= cfg_data;
          CFG_SHORT_WIRE:  short_wire_limit     <= cfg_data;
          CFG_BRAKE_HOLD:  brake_hold_pct       <= cfg_data[PCT_W-1:0];
          CFG_THR_FAULT:   throttle_fault_pct   <= cfg_data[PCT_W-1:0];
          CFG_THR_RELEASE: throttle_release_pct <= cfg_data[PCT_W-1:0];
          CFG_MIN_SPAN:    min_span             <= cfg_data;
          CFG_THR_DEAD:    throttle_dead_pct    <= cfg_data[PCT_W-1:0];
          CFG_BRAKE_DEAD:  brake_dead_pct       <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
      end

      // the finish step refills the register itself
      if (out_valid && out_ready && (state != S_FINISH)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            raw_q[0] <= throttle_a_raw;
            raw_q[1] <= throttle_b_raw;
            raw_q[2] <= brake_raw;
            for (int i = 0; i < N_SENSORS; i++) begin
              pct_q[i] <= '0;
            end
            dis_q  <= 1'b0;
            imp_q  <= 1'b0;
            sensor <= '0;
            if (op == OP_CALIBRATE) begin
              state <= S_CALIB;
            end else if (op == OP_DEADZONE) begin
              state <= S_DZ_START;
            end else if (op == OP_MEASURE) begin
              state <= S_MS_START;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_CALIB: begin
          low_mark[sensor]  <= lo_cal;
          high_mark[sensor] <= hi_cal;
          span[sensor]      <= sp_cal;
          if (last_sensor) begin
            state <= S_FINISH;
          end else begin
            sensor <= sensor + 1'b1;
          end
        end
        S_DZ_START: begin
          dz_prod <= NUM_W'(sp) * NUM_W'(dead_pct);
          state   <= S_DZ_WAIT;
        end
        S_DZ_WAIT: begin
          // a deadzone that would empty the span leaves the sensor alone
          if (dz_fits) begin
            low_mark[sensor] <= lo_dz;
            span[sensor]     <= sp - SB'(dz_val);
          end
          if (last_sensor) begin
            state <= S_FINISH;
          end else begin
            sensor <= sensor + 1'b1;
            state  <= S_DZ_START;
          end
        end
        S_MS_START: begin
          if (meas_skip) begin
            pct_q[sensor] <= '0;
            if (last_sensor) begin
              state <= S_FLAGS;
            end else begin
              sensor <= sensor + 1'b1;
            end
          end else begin
            state <= S_MS_WAIT;
          end
        end
        S_MS_WAIT: begin
          if (div_done) begin
            pct_q[sensor] <= pct_sat;
            if (last_sensor) begin
              state <= S_FLAGS;
            end else begin
              sensor <= sensor + 1'b1;
              state  <= S_MS_START;
            end
          end
        end
        S_FLAGS: begin
          dis_q       <= dis_next;
          imp_q       <= imp_next;
          fault_latch <= imp_next;
          state       <= S_FINISH;
        end
        S_FINISH: begin
          // wait for the output register to free
          if (!out_valid || out_ready) begin
            throttle_a_pct <= pct_q[0];
            throttle_b_pct <= pct_q[1];
            brake_pct      <= pct_q[2];
            ready_res      <= ready_next;
            disagree       <= dis_q;
            implausible    <= imp_q;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // spans start at one and every update keeps them above zero
  a_span_nonzero: assert property (@(posedge clk) disable iff (rst)
    (span[0] != '0) && (span[1] != '0) && (span[2] != '0))
    else $error("calibrated span reached zero");

  a_latch_in_flags: assert property (@(posedge clk) disable iff (rst)
    (fault_latch != $past(fault_latch)) |-> $past(state == S_FLAGS))
    else $error("fault latch moved outside the flag step");

  a_high_in_calib: assert property (@(posedge clk) disable iff (rst)
    ((high_mark[0] != $past(high_mark[0])) || (high_mark[1] != $past(high_mark[1]))
     || (high_mark[2] != $past(high_mark[2]))) |-> $past(state == S_CALIB))
    else $error("high mark moved outside calibration");

  a_div_done_waited: assert property (@(posedge clk) disable iff (rst)
    div_done |-> ((state == S_DZ_WAIT) || (state == S_MS_WAIT)))
    else $error("divider finished with nobody waiting");
`endif

endmodule

`default_nettype wire

// ===== tb/pedal_calibration_plausibility_tb.sv =====
// self-checking testbench for the pedal calibration and plausibility block
`timescale 1ns / 1ps

module pedal_calibration_plausibility_tb;
  import pcp_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_PHASES = 16;
  localparam int RANDOM_ITEMS = 1850;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] thr_a;
    logic [11:0] thr_b;
    logic [11:0] brk;
  } pedal_sample_t;

  typedef struct packed {
    logic [PCT_W-1:0] thr_a;
    logic [PCT_W-1:0] thr_b;
    logic [PCT_W-1:0] brk;
    logic             rdy;
    logic             dis;
    logic             imp;
  } pedal_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] op = OP_CALIBRATE;
  logic [11:0] throttle_a_raw = '0;
  logic [11:0] throttle_b_raw = '0;
  logic [11:0] brake_raw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [PCT_W-1:0] throttle_a_pct, throttle_b_pct, brake_pct;
  logic ready_res, disagree, implausible;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_OPEN_WIRE;
  logic [CFG_W-1:0] cfg_data = '0;

  pedal_calibration_plausibility DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op),
    .throttle_a_raw(throttle_a_raw), .throttle_b_raw(throttle_b_raw),
    .brake_raw(brake_raw),
    .out_valid(out_valid), .out_ready(out_ready),
    .throttle_a_pct(throttle_a_pct), .throttle_b_pct(throttle_b_pct),
    .brake_pct(brake_pct), .ready_res(ready_res), .disagree(disagree),
    .implausible(implausible),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the block state, sensor order throttle a, throttle b, brake
  int win_lo[3] = '{32767, 32767, 32767};
  int win_hi[3] = '{0, 0, 0};
  int win_span[3] = '{1, 1, 1};
  bit fault_held = 1'b0;
  int open_lim = 0, short_lim = 4095, hold_pct = 10, fault_pct = 25;
  int release_pct = 5, span_floor = 0, thr_dead = 5, brk_dead = 10;

  pedal_sample_t samples_to_send[$];
  pedal_result_t results_due[$];
  pedal_sample_t cur_sample;
  pedal_result_t got_res, want_res;
  int queued = 0, taken = 0, mismatches = 0;
  int tx_gap = 0, rx_gap = 0, hold_left = 0, hold_asks = 0, hold_done = 0;
  bit tx_burst = 1'b0, rx_burst = 1'b0;
  int cycles = 0;

  function automatic void track_extremes(int s, int raw);
    if (raw > win_hi[s]) win_hi[s] = raw;
    else if (raw < win_lo[s]) win_lo[s] = raw;
    if (win_hi[s] > win_lo[s]) win_span[s] = (win_hi[s] - win_lo[s]) & 'hFFF;
  endfunction

  // a deadzone that would swallow the whole span leaves the sensor alone
  function automatic void raise_floor(int s, int pct);
    int dz;
    dz = win_span[s] * pct / 100;
    if (dz >= win_span[s]) return;
    win_lo[s] = (win_lo[s] + dz) & 'h7FFF;
    win_span[s] = win_span[s] - dz;
  endfunction

  function automatic int position_pct(int s, int raw);
    int c, p;
    c = raw;
    if (c > win_hi[s]) c = win_hi[s];
    else if (c < win_lo[s]) c = win_lo[s];
    // window never calibrated: low mark still above high mark
    if (c < win_lo[s] || win_span[s] == 0) return 0;
    p = 100 * (c - win_lo[s]) / win_span[s];
    return (p > 100) ? 100 : p;
  endfunction

  function automatic pedal_result_t predict_pedal_result(pedal_sample_t smp);
    pedal_result_t r;
    int pa, pb, pbr, diff;
    r = '0;
    case (smp.op)
      OP_CALIBRATE: begin
        track_extremes(0, int'(smp.thr_a));
        track_extremes(1, int'(smp.thr_b));
        track_extremes(2, int'(smp.brk));
      end
      OP_DEADZONE: begin
        raise_floor(0, thr_dead);
        raise_floor(1, thr_dead);
        raise_floor(2, brk_dead);
      end
      OP_MEASURE: begin
        pa = position_pct(0, int'(smp.thr_a));
        pb = position_pct(1, int'(smp.thr_b));
        pbr = position_pct(2, int'(smp.brk));
        diff = (pa > pb) ? pa - pb : pb - pa;
        r.thr_a = PCT_W'(pa);
        r.thr_b = PCT_W'(pb);
        r.brk = PCT_W'(pbr);
        r.dis = (diff > DISAGREE_PCT
                 || smp.thr_a < open_lim || smp.thr_a > short_lim
                 || smp.thr_b < open_lim || smp.thr_b > short_lim);
        if (fault_held) r.imp = (pa > release_pct);
        else r.imp = (pbr >= hold_pct && pa > fault_pct);
        fault_held = r.imp;
      end
      default: ;
    endcase
    r.rdy = (win_span[0] > span_floor && win_span[1] > span_floor
             && win_span[2] > span_floor);
    return r;
  endfunction

  function automatic int pick_gap(bit burst);
    int r;
    r = int'($urandom_range(0, 99));
    if (burst || r < 55) return 0;
    if (r < 88) return int'($urandom_range(1, 3));
    if (r < 97) return int'($urandom_range(4, 12));
    return int'($urandom_range(20, 80));
  endfunction

  function automatic logic [11:0] near(int v, int spread);
    int x;
    x = v + int'($urandom_range(0, 2 * spread)) - spread;
    if (x < 0) x = 0;
    if (x > 4095) x = 4095;
    return 12'(x);
  endfunction

  // driver: offers queued samples, predicts at each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        results_due.push_back(predict_pedal_result(cur_sample));
        taken++;
      end
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (samples_to_send.size() != 0) begin
          cur_sample = samples_to_send.pop_front();
          op <= cur_sample.op;
          throttle_a_raw <= cur_sample.thr_a;
          throttle_b_raw <= cur_sample.thr_b;
          brake_raw <= cur_sample.brk;
          in_valid <= 1'b1;
          tx_gap = pick_gap(tx_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, pedal_result_t want, pedal_result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: exp a=%0d b=%0d br=%0d rdy=%0b dis=%0b imp=%0b",
                "  got a=%0d b=%0d br=%0d rdy=%0b dis=%0b imp=%0b"},
               what, want.thr_a, want.thr_b, want.brk, want.rdy, want.dis, want.imp,
               got.thr_a, got.thr_b, got.brk, got.rdy, got.dis, got.imp);
  endtask

  // monitor: random back-pressure, long holds on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_res = '{throttle_a_pct, throttle_b_pct, brake_pct,
                    ready_res, disagree, implausible};
        if (results_due.size() == 0) begin
          report("unexpected result", '0, got_res);
        end else begin
          want_res = results_due.pop_front();
          if (got_res !== want_res) report("result mismatch", want_res, got_res);
        end
        rx_gap = pick_gap(rx_burst);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (hold_asks != hold_done) begin
        hold_done++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic add_sample(logic [1:0] o, logic [11:0] a, logic [11:0] b,
                            logic [11:0] br);
    samples_to_send.push_back('{o, a, b, br});
    queued++;
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    case (idx)
      CFG_OPEN_WIRE:   open_lim = int'(data);
      CFG_SHORT_WIRE:  short_lim = int'(data);
      CFG_BRAKE_HOLD:  hold_pct = int'(data[PCT_W-1:0]);
      CFG_THR_FAULT:   fault_pct = int'(data[PCT_W-1:0]);
      CFG_THR_RELEASE: release_pct = int'(data[PCT_W-1:0]);
      CFG_MIN_SPAN:    span_floor = int'(data);
      CFG_THR_DEAD:    thr_dead = int'(data[PCT_W-1:0]);
      default:         brk_dead = int'(data[PCT_W-1:0]);
    endcase
  endtask

  // wait for every sample to be taken and every result to come back
  task automatic drain();
    while (taken != queued || results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // mode 0 all lowest, 1 all highest, 2 junk in the upper bits of percents
  task automatic load_settings(int mode);
    logic [CFG_W-1:0] pct[5];
    bit wide;
    wide = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < 5; i++)
      case (mode)
        0: pct[i] = '0;
        1: pct[i] = CFG_W'(PCT_FULL);
        2: pct[i] = CFG_W'($urandom_range(0, 4095));
        default: pct[i] = CFG_W'($urandom_range(0, 100));
      endcase
    case (mode)
      0: begin
        write_cfg(CFG_OPEN_WIRE, '0);
        write_cfg(CFG_SHORT_WIRE, '0);
        write_cfg(CFG_MIN_SPAN, '0);
      end
      1: begin
        write_cfg(CFG_OPEN_WIRE, 12'hFFF);
        write_cfg(CFG_SHORT_WIRE, 12'hFFF);
        write_cfg(CFG_MIN_SPAN, 12'hFFF);
      end
      default: begin
        write_cfg(CFG_OPEN_WIRE, wide ? CFG_W'($urandom_range(0, 4095))
                                      : CFG_W'($urandom_range(0, 300)));
        write_cfg(CFG_SHORT_WIRE, wide ? CFG_W'($urandom_range(0, 4095))
                                       : CFG_W'($urandom_range(3700, 4095)));
        write_cfg(CFG_MIN_SPAN, wide ? CFG_W'($urandom_range(0, 4095))
                                     : CFG_W'($urandom_range(0, 1500)));
      end
    endcase
    write_cfg(CFG_BRAKE_HOLD, pct[0]);
    write_cfg(CFG_THR_FAULT, pct[1]);
    write_cfg(CFG_THR_RELEASE, pct[2]);
    write_cfg(CFG_THR_DEAD, pct[3]);
    write_cfg(CFG_BRAKE_DEAD, pct[4]);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int start, roll, ncal, nmeas, a;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: untouched windows, unused op, full-scale sweep, latch set and clear
    add_sample(OP_MEASURE, 12'hFFF, 12'h000, 12'hFFF);
    add_sample(OP_UNUSED, 12'hFFF, 12'hFFF, 12'hFFF);
    add_sample(OP_DEADZONE, 12'h000, 12'h000, 12'h000);
    add_sample(OP_MEASURE, 12'h800, 12'h7FF, 12'h555);
    add_sample(OP_CALIBRATE, 12'hFFF, 12'hFFF, 12'hFFF);
    add_sample(OP_MEASURE, 12'hFFF, 12'hFFF, 12'hFFF);
    add_sample(OP_CALIBRATE, 12'h000, 12'h000, 12'h000);
    add_sample(OP_MEASURE, 12'hFFF, 12'hFFF, 12'hFFF);
    add_sample(OP_MEASURE, 12'h800, 12'h800, 12'h000);
    add_sample(OP_MEASURE, 12'h000, 12'h000, 12'h000);
    add_sample(OP_MEASURE, 12'hFFF, 12'h000, 12'h800);
    add_sample(OP_MEASURE, 12'h800, 12'h666, 12'hAAA);
    add_sample(OP_DEADZONE, 12'hFFF, 12'hFFF, 12'hFFF);
    add_sample(OP_MEASURE, 12'h064, 12'h064, 12'h064);
    add_sample(OP_MEASURE, 12'hFFF, 12'hFFF, 12'hFFF);
    add_sample(OP_UNUSED, 12'h000, 12'h000, 12'h000);
    add_sample(OP_CALIBRATE, 12'h7D0, 12'h7D0, 12'h7D0);
    add_sample(OP_MEASURE, 12'h9C4, 12'h834, 12'hFFF);
    add_sample(OP_DEADZONE, 12'h000, 12'h000, 12'h000);
    add_sample(OP_DEADZONE, 12'h000, 12'h000, 12'h000);
    add_sample(OP_MEASURE, 12'h0FF, 12'h100, 12'hF00);
    drain();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      load_settings(ph < 3 ? ph : 3);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      if (ph == 4 || ph == 9 || ph == 13) hold_asks++;
      if (ph == 1) add_sample(OP_DEADZONE, 12'hFFF, 12'h000, 12'hFFF);
      start = queued;
      while (queued - start < RANDOM_ITEMS / N_PHASES) begin
        roll = int'($urandom_range(0, 99));
        if (roll < 12) begin
          add_sample(2'($urandom_range(0, 3)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
        end else begin
          // calibration sweep, optional deadzone, then a run of measurements
          ncal = int'($urandom_range(0, 3));
          for (int k = 0; k < ncal; k++)
            add_sample(OP_CALIBRATE, 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
          if ($urandom_range(0, 2) == 0)
            add_sample(OP_DEADZONE, 12'($urandom_range(0, 4095)),
                       12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
          nmeas = int'($urandom_range(3, 12));
          for (int k = 0; k < nmeas; k++) begin
            a = int'($urandom_range(0, 4095));
            add_sample(OP_MEASURE, 12'(a),
                       ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 4095))
                                                   : near(a, 500),
                       12'($urandom_range(0, 4095)));
          end
        end
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && results_due.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/pcp_pkg.sv
hw/rtl/pcp_div.sv
hw/rtl/pedal_calibration_plausibility.sv
tb/pedal_calibration_plausibility_tb.sv
